@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: field widths,
// command and register codes, character codes and the queued operation.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 60;

  localparam int CMD_W      = 2;
  localparam int CODE_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // command codes
  localparam cmd_t CMD_PUT   = cmd_t'(0);
  localparam cmd_t CMD_READ  = cmd_t'(1);
  localparam cmd_t CMD_CLEAR = cmd_t'(2);

  // configuration register indexes
  localparam cfg_idx_t REG_COLOR = cfg_idx_t'(0);
  localparam cfg_idx_t REG_WIDE  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_TALL  = cfg_idx_t'(2);

  // character and attribute codes
  localparam code_t LF_CODE    = code_t'(10);
  localparam code_t CR_CODE    = code_t'(13);
  localparam code_t SPACE_CODE = code_t'(32);
  localparam code_t RESET_ATTR = code_t'(240);

  localparam logic RESET_WIDE = 1'b0;
  localparam logic RESET_TALL = 1'b1;

  // screen geometry choices, before saturation to the store size
  localparam int COLS_WIDE   = 40;
  localparam int COLS_NARROW = 80;
  localparam int ROWS_TALL   = 30;
  localparam int ROWS_SHORT  = 60;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_kind_t;

  // one classified item: cell position to touch plus the finished result
  typedef struct packed {
    op_kind_t kind;
    col_t     col;
    row_t     row;
    code_t    char_code;
    code_t    attr;
    col_t     res_col;
    row_t     res_row;
    logic     scroll;
    logic     oor;
  } op_t;

  typedef struct packed {
    col_t cols;
    row_t rows;
  } geo_t;

endpackage

@@ rtl/tcw_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_channels
// Valid/ready channels of the text console writer: command requests,
// results and configuration writes.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  logic          valid;
  logic          ready;
  tcw_pkg::cmd_t  cmd;
  tcw_pkg::code_t char_code;
  tcw_pkg::col_t  cell_col;
  tcw_pkg::row_t  cell_row;

  modport source (output valid, output cmd, output char_code, output cell_col,
                  output cell_row, input ready);
  modport sink (input valid, input cmd, input char_code, input cell_col,
                input cell_row, output ready);
endinterface

interface tcw_rsp_if;
  logic           valid;
  logic           ready;
  tcw_pkg::col_t  cursor_col;
  tcw_pkg::row_t  cursor_row;
  tcw_pkg::code_t read_char;
  tcw_pkg::code_t read_attr;
  logic           scrolled;
  logic           out_of_range;

  modport source (output valid, output cursor_col, output cursor_row,
                  output read_char, output read_attr, output scrolled,
                  output out_of_range, input ready);
  modport sink (input valid, input cursor_col, input cursor_row,
                input read_char, input read_attr, input scrolled,
                input out_of_range, output ready);
endinterface

interface tcw_cfg_if;
  logic                                valid;
  logic                                ready;
  tcw_pkg::cfg_idx_t                   index;
  logic [tcw_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/text_console_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character/attribute cell store with cursor, wrap,
// newline, scroll, cell read-back and screen clear.
// ----------------------------------------------------------------------------
// Usage:
//   req : commands (put character, read cell, clear screen); one result per
//         command on rsp, in order. cfg : register writes (color attribute,
//         wide_chars, tall_chars), always ready; write only while idle.
//   A command is classified combinationally as it is accepted and queued
//   (two entries); the screen engine then takes one operation at a time:
//     put or newline without scroll : cell write (put only), then result
//     read                          : cell read, data capture, result
//     scroll                        : copy rows up, fill bottom row, result
//     clear                         : fill every cell, then result
//   Scroll and clear are paced by the single write port of the cell RAM,
//   one cell per cycle. After reset the store is swept to spaces in
//   attribute 240, cell by cell over all MAX_COLS*MAX_ROWS cells, with
//   req.ready low.
//   When rsp stalls the result register holds; the queue keeps taking
//   commands until it is full.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp,
  tcw_cfg_if.sink   cfg
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic          init_busy;
  tcw_pkg::op_t  push_op;
  tcw_pkg::op_t  head_op;
  tcw_pkg::geo_t geo;

  tcw_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_op      (push_op),
    .geo       (geo)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (head_op)
  );

  tcw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (head_op),
    .q_pop     (q_pop),
    .geo       (geo),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

endmodule

@@ rtl/tcw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tcw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Front end: configuration registers, cursor tracking and classification of
// each accepted command into a queued operation with its final result.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  tcw_req_if.sink        req,
  tcw_cfg_if.sink        cfg,
  input  logic           q_full,
  input  logic           init_busy,
  output logic           q_push,
  output tcw_pkg::op_t   q_op,
  output tcw_pkg::geo_t  geo
);

  localparam tcw_pkg::col_t ColsWide = tcw_pkg::col_t'(
    (tcw_pkg::COLS_WIDE > MAX_COLS) ? MAX_COLS : tcw_pkg::COLS_WIDE);
  localparam tcw_pkg::col_t ColsNarrow = tcw_pkg::col_t'(
    (tcw_pkg::COLS_NARROW > MAX_COLS) ? MAX_COLS : tcw_pkg::COLS_NARROW);
  localparam tcw_pkg::row_t RowsTall = tcw_pkg::row_t'(
    (tcw_pkg::ROWS_TALL > MAX_ROWS) ? MAX_ROWS : tcw_pkg::ROWS_TALL);
  localparam tcw_pkg::row_t RowsShort = tcw_pkg::row_t'(
    (tcw_pkg::ROWS_SHORT > MAX_ROWS) ? MAX_ROWS : tcw_pkg::ROWS_SHORT);

  tcw_pkg::code_t color_attr;
  logic           wide_chars;
  logic           tall_chars;
  tcw_pkg::col_t  cur_col;
  tcw_pkg::row_t  cur_row;

  logic           wide_new;
  logic           tall_new;
  tcw_pkg::col_t  cols_new;
  tcw_pkg::row_t  rows_new;
  logic           is_nl;
  tcw_pkg::col_t  col_inc;
  tcw_pkg::row_t  row_inc;

  assign req.ready = !q_full && !init_busy;
  assign cfg.ready = 1'b1;
  assign q_push    = req.valid && req.ready;

  assign geo.cols = wide_chars ? ColsWide : ColsNarrow;
  assign geo.rows = tall_chars ? RowsTall : RowsShort;

  // geometry after the pending configuration write, for the cursor clamp
  assign wide_new = (cfg.index == tcw_pkg::REG_WIDE) ? cfg.data[0] : wide_chars;
  assign tall_new = (cfg.index == tcw_pkg::REG_TALL) ? cfg.data[0] : tall_chars;
  assign cols_new = wide_new ? ColsWide : ColsNarrow;
  assign rows_new = tall_new ? RowsTall : RowsShort;

  assign is_nl   = (req.char_code == tcw_pkg::LF_CODE) || (req.char_code == tcw_pkg::CR_CODE);
  assign col_inc = cur_col + 1'b1;
  assign row_inc = cur_row + 1'b1;

  always_comb begin
    q_op           = '0;
    q_op.kind      = tcw_pkg::OP_NOP;
    q_op.res_col   = cur_col;
    q_op.res_row   = cur_row;
    q_op.attr      = color_attr;
    q_op.char_code = req.char_code;
    unique case (req.cmd)
      tcw_pkg::CMD_PUT: begin
        q_op.kind = is_nl ? tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
        q_op.col  = cur_col;
        q_op.row  = cur_row;
        if (is_nl || (col_inc >= geo.cols)) begin
          q_op.res_col = '0;
          // past the last row: scroll, cursor stays on the bottom row
          if (row_inc >= geo.rows) begin
            q_op.scroll = 1'b1;
          end else begin
            q_op.res_row = row_inc;
          end
        end else begin
          q_op.res_col = col_inc;
        end
      end
      tcw_pkg::CMD_READ: begin
        q_op.kind = tcw_pkg::OP_READ;
        q_op.col  = req.cell_col;
        q_op.row  = req.cell_row;
        q_op.oor  = (req.cell_col >= geo.cols) || (req.cell_row >= geo.rows);
      end
      tcw_pkg::CMD_CLEAR: begin
        q_op.kind    = tcw_pkg::OP_CLEAR;
        q_op.res_col = '0;
        q_op.res_row = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_attr <= tcw_pkg::RESET_ATTR;
      wide_chars <= tcw_pkg::RESET_WIDE;
      tall_chars <= tcw_pkg::RESET_TALL;
      cur_col    <= '0;
      cur_row    <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == tcw_pkg::REG_COLOR) begin
        color_attr <= cfg.data;
      end
      if ((cfg.index == tcw_pkg::REG_WIDE) || (cfg.index == tcw_pkg::REG_TALL)) begin
        wide_chars <= wide_new;
        tall_chars <= tall_new;
        if (cur_col >= cols_new) begin
          cur_col <= cols_new - 1'b1;
        end
        if (cur_row >= rows_new) begin
          cur_row <= rows_new - 1'b1;
        end
      end
    end else if (q_push) begin
      cur_col <= q_op.res_col;
      cur_row <= q_op.res_row;
    end
  end

endmodule

@@ rtl/tcw_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Short FIFO of classified operations between the front end and the
// screen engine.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tcw_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output tcw_pkg::op_t head
);

  localparam int Depth = tcw_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  tcw_pkg::op_t    slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tcw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Screen engine: owns the cell store, carries out writes, reads, scrolls
// and clears one operation at a time, and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tcw_pkg::op_t  q_head,
  output logic          q_pop,
  input  tcw_pkg::geo_t geo,
  output logic          init_busy,
  tcw_rsp_if.source     rsp
);

  localparam int Cells = MAX_COLS * MAX_ROWS;
  localparam int Aw    = $clog2(Cells);
  localparam int Aw1   = Aw + 1;
  localparam int DataW = 2 * tcw_pkg::CODE_W;
  localparam logic [Aw-1:0] CellLast = Aw'(Cells - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_FILL,
    S_DONE
  } state_t;

  state_t          state;
  logic [Aw-1:0]   idx;
  tcw_pkg::op_t    cur_op;
  tcw_pkg::code_t  rd_char;
  tcw_pkg::code_t  rd_attr;

  logic            rsp_valid;
  tcw_pkg::col_t   rsp_col;
  tcw_pkg::row_t   rsp_row;
  tcw_pkg::code_t  rsp_char;
  tcw_pkg::code_t  rsp_attr;
  logic            rsp_scrolled;
  logic            rsp_oor;

  logic [Aw:0]     total_w;
  logic [Aw-1:0]   last_r;
  logic [Aw-1:0]   keep_r;
  logic [Aw-1:0]   cols_aw;
  logic [Aw-1:0]   head_addr;
  logic [Aw-1:0]   fill_end;
  tcw_pkg::code_t  fill_attr;
  logic            out_ok;

  logic             ram_we;
  logic [Aw-1:0]    ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic [Aw-1:0]    ram_raddr;
  logic [DataW-1:0] ram_rdata;

  tcw_ram #(
    .WIDTH (DataW),
    .DEPTH (Cells)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the user must change geometry only while idle (not enforced here), so a registered copy is in time
  assign total_w = Aw1'(geo.rows) * Aw1'(geo.cols);
  always_ff @(posedge clk) begin
    last_r <= Aw'(total_w - 1'b1);
    keep_r <= Aw'(total_w - Aw1'(geo.cols));
  end

  assign cols_aw   = Aw'(geo.cols);
  assign head_addr = Aw'(q_head.row) * cols_aw + Aw'(q_head.col);
  assign fill_end  = init_busy ? CellLast : last_r;
  assign fill_attr = init_busy ? tcw_pkg::RESET_ATTR : cur_op.attr;
  assign out_ok    = !rsp_valid || rsp.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {tcw_pkg::SPACE_CODE, fill_attr};
    ram_raddr = head_addr;
    q_pop     = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid && (q_head.kind == tcw_pkg::OP_PUT)) begin
          ram_we    = 1'b1;
          ram_waddr = head_addr;
          ram_wdata = {q_head.char_code, q_head.attr};
        end
      end
      S_COPY: begin
        // read one row ahead, write back the cell read last cycle
        ram_raddr = idx + cols_aw;
        if (idx != '0) begin
          ram_we    = 1'b1;
          ram_waddr = idx - 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_READ, S_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      idx       <= '0;
      init_busy <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_ok) begin
        rsp_valid    <= 1'b1;
        rsp_col      <= cur_op.res_col;
        rsp_row      <= cur_op.res_row;
        rsp_char     <= rd_char;
        rsp_attr     <= rd_attr;
        rsp_scrolled <= cur_op.scroll;
        rsp_oor      <= cur_op.oor;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_op  <= q_head;
            rd_char <= '0;
            rd_attr <= '0;
            idx     <= '0;
            unique case (q_head.kind)
              tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE:
                state <= q_head.scroll ? S_COPY : S_DONE;
              tcw_pkg::OP_READ:
                state <= q_head.oor ? S_DONE : S_READ;
              tcw_pkg::OP_CLEAR:
                state <= S_FILL;
              default:
                state <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          rd_char <= ram_rdata[DataW-1:tcw_pkg::CODE_W];
          rd_attr <= ram_rdata[tcw_pkg::CODE_W-1:0];
          state   <= S_DONE;
        end
        S_COPY: begin
          if (idx == keep_r) begin
            state <= S_FILL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FILL: begin
          if (idx == fill_end) begin
            idx <= '0;
            if (init_busy) begin
              init_busy <= 1'b0;
              state     <= S_IDLE;
            end else begin
              state <= S_DONE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (out_ok) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.cursor_col   = rsp_col;
  assign rsp.cursor_row   = rsp_row;
  assign rsp.read_char    = rsp_char;
  assign rsp.read_attr    = rsp_attr;
  assign rsp.scrolled     = rsp_scrolled;
  assign rsp.out_of_range = rsp_oor;

endmodule

@@ rtl/tcw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tcw_pkg::col_t  rsp_cursor_col,
  input tcw_pkg::row_t  rsp_cursor_row,
  input tcw_pkg::code_t rsp_read_char,
  input tcw_pkg::code_t rsp_read_attr,
  input logic           rsp_scrolled,
  input logic           rsp_out_of_range
);

  // a stalled result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_col) &&
      $stable(rsp_cursor_row) && $stable(rsp_read_char) &&
      $stable(rsp_read_attr) && $stable(rsp_scrolled) && $stable(rsp_out_of_range))
    else $error("result changed while stalled");

  // rejected read returns no data and is not a put
  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_out_of_range |->
      rsp_read_char == '0 && rsp_read_attr == '0 && !rsp_scrolled)
    else $error("out-of-range read carries data or scroll");

  // a scroll only comes from a line break, which homes the column
  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_scrolled |-> rsp_cursor_col == '0)
    else $error("scroll with cursor off column zero");

  // store sweep after reset blocks commands
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("commands taken during reset sweep");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_cursor_col   (rsp.cursor_col),
  .rsp_cursor_row   (rsp.cursor_row),
  .rsp_read_char    (rsp.read_char),
  .rsp_read_attr    (rsp.read_attr),
  .rsp_scrolled     (rsp.scrolled),
  .rsp_out_of_range (rsp.out_of_range)
);

@@ dv/tb_text_console_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A cell-level screen
// tracker predicts cursor, scroll, read-back and range flags for every
// accepted command and checks each response in order. Stimulus opens with
// directed edge cases, then random command mixes run at all four screen
// geometries, with sender gaps, receiver stalls and one long response
// hold-off.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int   CLK_PERIOD      = 12;
  localparam int   CELLS           = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam cmd_t CMD_UNUSED      = cmd_t'(3);
  localparam int   STALL_LIMIT     = 30000;
  localparam int   HOLD_OFF_CYCLES = 400;
  localparam int   MAX_REPORTS     = 10;

  typedef struct packed {
    col_t  col;
    row_t  row;
    code_t rd_char;
    code_t rd_attr;
    logic  scrolled;
    logic  oor;
  } screen_result_t;

  // Tracks the screen contents and cursor; queues one expected response
  // per accepted command.
  class screen_tracker;
    byte unsigned   char_mem[CELLS];
    byte unsigned   attr_mem[CELLS];
    col_t           cur_col;
    row_t           cur_row;
    logic [7:0]     attr;
    logic           wide;
    logic           tall;
    screen_result_t due_results[$];
    int             errors;

    function new();
      foreach (char_mem[i]) begin
        char_mem[i] = SPACE_CODE;
        attr_mem[i] = RESET_ATTR;
      end
      cur_col = '0;
      cur_row = '0;
      attr    = RESET_ATTR;
      wide    = RESET_WIDE;
      tall    = RESET_TALL;
      errors  = 0;
    endfunction

    function int cols();
      int c;
      c = wide ? COLS_WIDE : COLS_NARROW;
      return (c > MAX_COLS_DEF) ? MAX_COLS_DEF : c;
    endfunction

    function int rows();
      int r;
      r = tall ? ROWS_TALL : ROWS_SHORT;
      return (r > MAX_ROWS_DEF) ? MAX_ROWS_DEF : r;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_COLOR: attr = value;
        REG_WIDE:  wide = value[0];
        REG_TALL:  tall = value[0];
        default: ;
      endcase
      // a smaller geometry pulls the cursor back onto the screen
      if (cur_col >= cols()) cur_col = col_t'(cols() - 1);
      if (cur_row >= rows()) cur_row = row_t'(rows() - 1);
    endfunction

    // column 0 of the next row; scrolls when past the bottom, returns 1 then
    function logic next_line();
      int c, r, total;
      c = cols();
      r = rows();
      cur_col = '0;
      if (int'(cur_row) + 1 < r) begin
        cur_row++;
        return 1'b0;
      end
      total = c * r;
      for (int i = 0; i < total - c; i++) begin
        char_mem[i] = char_mem[i + c];
        attr_mem[i] = attr_mem[i + c];
      end
      for (int i = total - c; i < total; i++) begin
        char_mem[i] = SPACE_CODE;
        attr_mem[i] = attr;
      end
      cur_row = row_t'(r - 1);
      return 1'b1;
    endfunction

    function void apply_cmd(cmd_t op, code_t code, col_t rc, row_t rr);
      screen_result_t res;
      int c, r, addr;
      c   = cols();
      r   = rows();
      res = '0;
      case (op)
        CMD_PUT: begin
          if (code == LF_CODE || code == CR_CODE) begin
            res.scrolled = next_line();
          end else begin
            addr = int'(cur_row) * c + int'(cur_col);
            char_mem[addr] = code;
            attr_mem[addr] = attr;
            if (int'(cur_col) + 1 >= c) res.scrolled = next_line();
            else cur_col++;
          end
        end
        CMD_READ: begin
          if (int'(rc) >= c || int'(rr) >= r) begin
            res.oor = 1'b1;
          end else begin
            addr = int'(rr) * c + int'(rc);
            res.rd_char = char_mem[addr];
            res.rd_attr = attr_mem[addr];
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < c * r; i++) begin
            char_mem[i] = SPACE_CODE;
            attr_mem[i] = attr;
          end
          cur_col = '0;
          cur_row = '0;
        end
        default: ;
      endcase
      res.col = cur_col;
      res.row = cur_row;
      due_results.push_back(res);
    endfunction

    function void check_response(screen_result_t got);
      screen_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: response with nothing outstanding: col %0d row %0d", $time,
                   got.col, got.row);
        return;
      end
      want = due_results.pop_front();
      if (got.col !== want.col || got.row !== want.row ||
          got.rd_char !== want.rd_char || got.rd_attr !== want.rd_attr ||
          got.scrolled !== want.scrolled || got.oor !== want.oor) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch exp col %0d row %0d char %0d attr %0d scr %0b oor %0b",
                   $time, want.col, want.row, want.rd_char, want.rd_attr,
                   want.scrolled, want.oor);
          $display("%0t:          got col %0d row %0d char %0d attr %0d scr %0b oor %0b",
                   $time, got.col, got.row, got.rd_char, got.rd_attr,
                   got.scrolled, got.oor);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  tcw_req_if req_if ();
  tcw_rsp_if rsp_if ();
  tcw_cfg_if cfg_if ();

  text_console_writer u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  screen_tracker sb;
  int            src_idle_pct;
  int            rcv_stall_pct;
  logic          hold_rsp;
  int            quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_if.ready = !hold_rsp && ($urandom_range(99) >= rcv_stall_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        sb.apply_cmd(req_if.cmd, req_if.char_code, req_if.cell_col, req_if.cell_row);
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response('{col: rsp_if.cursor_col, row: rsp_if.cursor_row,
                            rd_char: rsp_if.read_char, rd_attr: rsp_if.read_attr,
                            scrolled: rsp_if.scrolled, oor: rsp_if.out_of_range});
        moved = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.index, cfg_if.data);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_cmd(cmd_t op, code_t code, col_t rc, row_t rr);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid     = 1'b1;
    req_if.cmd       = op;
    req_if.char_code = code;
    req_if.cell_col  = rc;
    req_if.cell_row  = rr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_cmds(int count, int lf_pct);
    int    pick;
    cmd_t  op;
    code_t code;
    col_t  rc;
    row_t  rr;
    repeat (count) begin
      pick = $urandom_range(999);
      code = code_t'($urandom_range(255));
      rc   = col_t'($urandom_range(79));
      rr   = row_t'($urandom_range(59));
      if (pick < 5) begin
        op = CMD_CLEAR;
      end else if (pick < 25) begin
        op = CMD_UNUSED;
      end else if (pick < 305) begin
        op = CMD_READ;
        // mostly on screen, often on the cursor row where text was just put
        if ($urandom_range(4) != 0) begin
          rc = col_t'($urandom_range(sb.cols() - 1));
          rr = $urandom_range(1) ? sb.cur_row : row_t'($urandom_range(sb.rows() - 1));
        end
      end else begin
        op = CMD_PUT;
        if ($urandom_range(99) < lf_pct) code = $urandom_range(1) ? LF_CODE : CR_CODE;
      end
      send_cmd(op, code, rc, rr);
    end
  endtask

  task automatic run_phase(logic [7:0] attr_val, logic wide_val, logic tall_val,
                           int src_pct, int rcv_pct, int count, int lf_pct,
                           bit long_hold);
    wait_drained();
    set_reg(REG_COLOR, attr_val);
    set_reg(REG_WIDE, CFG_DATA_W'(wide_val));
    set_reg(REG_TALL, CFG_DATA_W'(tall_val));
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    if (long_hold) begin
      fork
        begin
          hold_rsp = 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_rsp = 1'b0;
        end
      join_none
    end
    random_cmds(count, lf_pct);
  endtask

  initial begin
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_PUT;
    req_if.char_code = '0;
    req_if.cell_col  = '0;
    req_if.cell_row  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_COLOR;
    cfg_if.data      = '0;
    rsp_if.ready     = 1'b0;
    hold_rsp         = 1'b0;
    src_idle_pct     = 0;
    rcv_stall_pct    = 0;
    quiet_cycles     = 0;
    sb               = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry is 80 x 30; the first transfer waits out the store sweep
    send_cmd(CMD_READ, 8'h00, 7'd0, 6'd0);
    send_cmd(CMD_READ, 8'hFF, 7'd79, 6'd29);
    send_cmd(CMD_READ, 8'h00, 7'd0, 6'd30);
    send_cmd(CMD_READ, 8'h00, 7'd79, 6'd59);
    send_cmd(CMD_PUT, 8'h41, 7'd0, 6'd0);
    send_cmd(CMD_PUT, 8'hFF, 7'd79, 6'd59);
    send_cmd(CMD_PUT, 8'h00, 7'd0, 6'd0);
    send_cmd(CMD_READ, 8'h00, 7'd1, 6'd0);
    send_cmd(CMD_UNUSED, 8'hFF, 7'd79, 6'd59);
    send_cmd(CMD_PUT, LF_CODE, 7'd0, 6'd0);
    send_cmd(CMD_PUT, CR_CODE, 7'd0, 6'd0);
    send_cmd(CMD_PUT, 8'h7E, 7'd0, 6'd0);
    send_cmd(CMD_READ, 8'h00, 7'd0, 6'd2);
    send_cmd(CMD_CLEAR, 8'h00, 7'd0, 6'd0);
    send_cmd(CMD_READ, 8'h00, 7'd1, 6'd0);
    // walk down to the bottom row, then a newline there scrolls
    repeat (29) send_cmd(CMD_PUT, LF_CODE, 7'd0, 6'd0);
    send_cmd(CMD_PUT, 8'h5A, 7'd0, 6'd0);
    send_cmd(CMD_PUT, CR_CODE, 7'd0, 6'd0);
    send_cmd(CMD_READ, 8'h00, 7'd0, 6'd28);
    send_cmd(CMD_READ, 8'h00, 7'd0, 6'd29);

    run_phase(8'h00, 1'b1, 1'b1, 0, 0, 250, 35, 1'b0);
    run_phase(8'hFF, 1'b1, 1'b0, 80, 0, 150, 40, 1'b0);
    run_phase(8'($urandom_range(255)), 1'b0, 1'b1, 0, 80, 150, 30, 1'b1);
    run_phase(8'($urandom_range(255)), 1'b0, 1'b0, 23, 23, 100, 70, 1'b0);
    run_phase(8'($urandom_range(255)), 1'b1, 1'b1, 23, 23, 150, 35, 1'b0);

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
